FILE: rtl/clp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// clp_pkg
// Shared constants, codes and types of the country line parser.
// ----------------------------------------------------------------------------
package clp_pkg;

  localparam int NAME_LIMIT = 64;
  localparam int POP_BITS   = 32;

  localparam int CHAR_W     = 8;
  localparam int NAME_CNT_W = $clog2(NAME_LIMIT + 1);
  localparam int NAME_LEN_W = 7;
  localparam int OUT_POP_W  = 32;
  localparam int STATUS_W   = 3;

  localparam logic [CHAR_W-1:0] CH_COMMA   = 8'h2C;
  localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_ZERO    = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE    = 8'h39;

  localparam logic KIND_NAME    = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK          = 3'd0,
    ST_NO_COMMA    = 3'd1,
    ST_MANY_COMMAS = 3'd2,
    ST_EMPTY_NAME  = 3'd3,
    ST_NAME_LONG   = 3'd4,
    ST_NONDIGIT    = 3'd5,
    ST_EMPTY_POP   = 3'd6,
    ST_OVERFLOW    = 3'd7
  } status_t;

  typedef struct packed {
    logic [CHAR_W-1:0] char_code;
    logic              line_end;
  } item_t;

  typedef struct packed {
    logic                  kind;
    logic [CHAR_W-1:0]     name_byte;
    status_t               status;
    logic [NAME_LEN_W-1:0] name_length;
    logic [OUT_POP_W-1:0]  population;
  } result_t;

endpackage
`default_nettype wire

FILE: rtl/clp_in_reg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// clp_in_reg
// Input register: captures one byte transaction and holds it until the
// parse stage takes it.
// ----------------------------------------------------------------------------
module clp_in_reg (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  input  wire logic [clp_pkg::CHAR_W-1:0] in_char_code,
  input  wire logic                       in_line_end,
  output logic                            in_stall,
  input  wire logic                       advance,
  output clp_pkg::item_t                  item,
  output logic                            item_valid
);
  import clp_pkg::*;

  item_t item_r;
  logic  valid_r;

  assign in_stall   = valid_r && !advance;
  assign item       = item_r;
  assign item_valid = valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (!in_stall) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      item_r.char_code <= in_char_code;
      item_r.line_end  <= in_line_end;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/clp_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// clp_core
// Parse stage: line state update, status priority and result register.
// ----------------------------------------------------------------------------
module clp_core (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  clp_pkg::item_t        item,
  input  wire logic             item_valid,
  output logic                  advance,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output clp_pkg::result_t      result
);
  import clp_pkg::*;

  localparam int WIDE_W = POP_BITS + 4;
  localparam logic [POP_BITS-1:0] POP_MAX = {POP_BITS{1'b1}};

  logic [1:0]            comma_count_r, comma_count_nxt;
  logic [NAME_CNT_W-1:0] name_count_r, name_count_nxt;
  logic [POP_BITS-1:0]   pop_value_r, pop_value_nxt;
  logic                  seen_r, seen_nxt;
  logic                  closed_r, closed_nxt;
  logic                  bad_r, bad_nxt;
  logic                  ovf_r, ovf_nxt;

  result_t               result_r, result_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic                  produce;
  logic                  take;

  logic                  is_digit;
  logic [3:0]            digit;
  logic [WIDE_W-1:0]     pop_wide;
  logic [WIDE_W-1:0]     pop_next_wide;
  status_t               st;

  assign advance   = !out_valid_r || !out_stall;
  assign take      = item_valid && advance;
  assign out_valid = out_valid_r;
  assign result    = result_r;

  assign is_digit      = (item.char_code >= CH_ZERO) && (item.char_code <= CH_NINE);
  assign digit         = 4'(item.char_code - CH_ZERO);
  assign pop_wide      = WIDE_W'(pop_value_r);
  assign pop_next_wide = (pop_wide << 3) + (pop_wide << 1) + WIDE_W'(digit);

  always_comb begin
    priority if (comma_count_r == 2'd0)                        st = ST_NO_COMMA;
    else if (comma_count_r >= 2'd2)                            st = ST_MANY_COMMAS;
    else if (name_count_r == '0)                               st = ST_EMPTY_NAME;
    else if (name_count_r >= NAME_CNT_W'(NAME_LIMIT))          st = ST_NAME_LONG;
    else if (bad_r)                                            st = ST_NONDIGIT;
    else if (!seen_r)                                          st = ST_EMPTY_POP;
    else if (ovf_r)                                            st = ST_OVERFLOW;
    else                                                       st = ST_OK;
  end

  always_comb begin
    comma_count_nxt = comma_count_r;
    name_count_nxt  = name_count_r;
    pop_value_nxt   = pop_value_r;
    seen_nxt        = seen_r;
    closed_nxt      = closed_r;
    bad_nxt         = bad_r;
    ovf_nxt         = ovf_r;
    produce         = 1'b0;
    result_nxt      = '0;
    result_nxt.status = ST_OK;

    if (take) begin
      priority if (item.line_end) begin
        produce                = 1'b1;
        result_nxt.kind        = KIND_SUMMARY;
        result_nxt.status      = st;
        result_nxt.name_length = NAME_LEN_W'(name_count_r);
        if (st == ST_OK || st == ST_OVERFLOW) begin
          result_nxt.population = OUT_POP_W'(pop_value_r);
        end
        comma_count_nxt = '0;
        name_count_nxt  = '0;
        pop_value_nxt   = '0;
        seen_nxt        = 1'b0;
        closed_nxt      = 1'b0;
        bad_nxt         = 1'b0;
        ovf_nxt         = 1'b0;
      end else if (item.char_code == CH_COMMA) begin
        if (comma_count_r < 2'd2) begin
          comma_count_nxt = comma_count_r + 2'd1;
        end
      end else if (comma_count_r == 2'd0) begin
        if (name_count_r < NAME_CNT_W'(NAME_LIMIT)) begin
          name_count_nxt = name_count_r + NAME_CNT_W'(1);
        end
        produce              = 1'b1;
        result_nxt.kind      = KIND_NAME;
        result_nxt.name_byte = item.char_code;
      end else if (!closed_r) begin
        priority if (item.char_code == CH_NEWLINE) begin
          closed_nxt = 1'b1;
        end else if (is_digit) begin
          seen_nxt = 1'b1;
          if (!bad_r && !ovf_r) begin
            if (pop_next_wide[WIDE_W-1:POP_BITS] != '0) begin
              ovf_nxt       = 1'b1;
              pop_value_nxt = POP_MAX;
            end else begin
              pop_value_nxt = pop_next_wide[POP_BITS-1:0];
            end
          end
        end else begin
          bad_nxt = 1'b1;
        end
      end else begin
        // non-comma bytes after the newline are ignored
      end
    end

    out_valid_nxt = advance ? produce : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      comma_count_r <= '0;
      name_count_r  <= '0;
      pop_value_r   <= '0;
      seen_r        <= 1'b0;
      closed_r      <= 1'b0;
      bad_r         <= 1'b0;
      ovf_r         <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      comma_count_r <= comma_count_nxt;
      name_count_r  <= name_count_nxt;
      pop_value_r   <= pop_value_nxt;
      seen_r        <= seen_nxt;
      closed_r      <= closed_nxt;
      bad_r         <= bad_nxt;
      ovf_r         <= ovf_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result_r <= result_nxt;
    end
  end

  a_comma_sat: assert property (@(posedge clk) disable iff (!rst_n)
    comma_count_r != 2'd3)
    else $error("comma count past saturation");

  a_name_sat: assert property (@(posedge clk) disable iff (!rst_n)
    name_count_r <= NAME_CNT_W'(NAME_LIMIT))
    else $error("name count past limit");

  a_clear_after_end: assert property (@(posedge clk) disable iff (!rst_n)
    (take && item.line_end) |=> (comma_count_r == 2'd0 && name_count_r == '0 &&
                                 !seen_r && !closed_r && !bad_r && !ovf_r))
    else $error("line state not cleared after terminator");

  a_ovf_value: assert property (@(posedge clk) disable iff (!rst_n)
    ovf_r |-> pop_value_r == POP_MAX)
    else $error("overflow without saturated value");

  a_name_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && result_r.kind == KIND_NAME) |->
      (result_r.status == ST_OK && result_r.population == '0))
    else $error("name byte result carries summary fields");

endmodule
`default_nettype wire

FILE: rtl/country_line_parser.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// country_line_parser
// Byte-stream parser for "name,population" lines with per-line summary.
//
//   channel | direction | handshake         | payload
//   in_     | input     | in_valid/in_stall | char_code[7:0], line_end
//   out_    | output    | out_valid/out_stall | kind, name_byte[7:0], status[2:0],
//           |           |                   | name_length[6:0], population[31:0]
//
// One byte per cycle while the output is not stalled; a result passes through
// the input register, then the result register, after its transaction is accepted.
// The population accumulator (x10 + digit and overflow check) is updated
// combinationally for each accepted byte and then registered.
// Reset is synchronous; all line state clears to an empty line.
// A stalled result holds the parse stage, which stalls the input once the
// input register is full.
// ----------------------------------------------------------------------------
module country_line_parser (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic [clp_pkg::CHAR_W-1:0]     in_char_code,
  input  wire logic                           in_line_end,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic                                out_kind,
  output logic [clp_pkg::CHAR_W-1:0]          out_name_byte,
  output logic [clp_pkg::STATUS_W-1:0]        out_status,
  output logic [clp_pkg::NAME_LEN_W-1:0]      out_name_length,
  output logic [clp_pkg::OUT_POP_W-1:0]       out_population
);
  import clp_pkg::*;

  item_t   item;
  logic    item_valid;
  logic    advance;
  result_t result;

  clp_in_reg u_in_reg (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_char_code (in_char_code),
    .in_line_end  (in_line_end),
    .in_stall     (in_stall),
    .advance      (advance),
    .item         (item),
    .item_valid   (item_valid)
  );

  clp_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .item       (item),
    .item_valid (item_valid),
    .advance    (advance),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .result     (result)
  );

  assign out_kind        = result.kind;
  assign out_name_byte   = result.name_byte;
  assign out_status      = result.status;
  assign out_name_length = result.name_length;
  assign out_population  = result.population;

endmodule
`default_nettype wire

FILE: tb/clp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clp_checker
// Watches both channels of the country line parser. Every accepted input
// transaction runs through a line-parse predictor, and any name byte or
// line summary it produces is queued. Each accepted result is compared
// field by field with the oldest queued one.
// ----------------------------------------------------------------------------
module clp_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_stall,
  input  logic [clp_pkg::CHAR_W-1:0]     in_char_code,
  input  logic                           in_line_end,
  input  logic                           out_valid,
  input  logic                           out_stall,
  input  logic                           out_kind,
  input  logic [clp_pkg::CHAR_W-1:0]     out_name_byte,
  input  logic [clp_pkg::STATUS_W-1:0]   out_status,
  input  logic [clp_pkg::NAME_LEN_W-1:0] out_name_length,
  input  logic [clp_pkg::OUT_POP_W-1:0]  out_population,
  output int                             fail_count,
  output int                             pending
);
  import clp_pkg::*;

  result_t         line_results_q[$];

  logic [1:0]      commas_seen;
  int unsigned     name_chars;
  longint unsigned pop_acc;
  bit              saw_digit;
  bit              pop_done;
  bit              bad_char;
  bit              pop_ovf;

  function automatic void clear_line();
    commas_seen = '0;
    name_chars  = 0;
    pop_acc     = 0;
    saw_digit   = 1'b0;
    pop_done    = 1'b0;
    bad_char    = 1'b0;
    pop_ovf     = 1'b0;
  endfunction

  function automatic bit parse_char(input logic [CHAR_W-1:0] c, input logic le,
                                    output result_t r);
    longint unsigned d;
    longint unsigned pop_max;
    status_t         st;
    r       = '0;
    pop_max = (~64'd0) >> (64 - POP_BITS);
    if (le) begin
      if (commas_seen == 2'd0) st = ST_NO_COMMA;
      else if (commas_seen >= 2'd2) st = ST_MANY_COMMAS;
      else if (name_chars == 0) st = ST_EMPTY_NAME;
      else if (name_chars >= NAME_LIMIT) st = ST_NAME_LONG;
      else if (bad_char) st = ST_NONDIGIT;
      else if (!saw_digit) st = ST_EMPTY_POP;
      else if (pop_ovf) st = ST_OVERFLOW;
      else st = ST_OK;
      r.kind        = KIND_SUMMARY;
      r.status      = st;
      r.name_length = NAME_LEN_W'(name_chars);
      if (st == ST_OK || st == ST_OVERFLOW) r.population = OUT_POP_W'(pop_acc);
      clear_line();
      return 1'b1;
    end
    if (c == CH_COMMA) begin
      if (commas_seen < 2'd2) commas_seen++;
      return 1'b0;
    end
    if (commas_seen == 2'd0) begin
      if (name_chars < NAME_LIMIT) name_chars++;
      r.kind      = KIND_NAME;
      r.name_byte = c;
      return 1'b1;
    end
    if (pop_done) return 1'b0;
    if (c == CH_NEWLINE) begin
      pop_done = 1'b1;
    end else if (c >= CH_ZERO && c <= CH_NINE) begin
      d         = longint'(c - CH_ZERO);
      saw_digit = 1'b1;
      if (!bad_char && !pop_ovf) begin
        if (pop_acc > (pop_max - d) / 10) begin
          pop_ovf = 1'b1;
          pop_acc = pop_max;
        end else begin
          pop_acc = pop_acc * 10 + d;
        end
      end
    end else begin
      bad_char = 1'b1;
    end
    return 1'b0;
  endfunction

  task automatic check_field(input string field, input longint unsigned want,
                             input longint unsigned seen);
    if (want != seen) begin
      $error("%s mismatch: expected 0x%0h, actual 0x%0h", field, want, seen);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    result_t want_r;
    if (!rst_n) begin
      clear_line();
      line_results_q.delete();
    end else begin
      if (in_valid && !in_stall) begin
        if (parse_char(in_char_code, in_line_end, want_r)) line_results_q.push_back(want_r);
      end
      if (out_valid && !out_stall) begin
        if (line_results_q.size() == 0) begin
          $error("unexpected result: kind %0b byte 0x%0h status %0d length %0d pop %0d",
                 out_kind, out_name_byte, out_status, out_name_length, out_population);
          fail_count++;
        end else begin
          want_r = line_results_q.pop_front();
          check_field("kind", want_r.kind, out_kind);
          check_field("name_byte", want_r.name_byte, out_name_byte);
          check_field("status", want_r.status, out_status);
          check_field("name_length", want_r.name_length, out_name_length);
          check_field("population", want_r.population, out_population);
        end
      end
    end
    pending = line_results_q.size();
  end

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Regression for the country line parser. Directed lines cover each status,
// the status priority, name and comma saturation, bytes after the newline
// and overflow; random lines follow, mostly well formed with random content,
// the rest noise. Both channels see random idle gaps and bursts.
// ----------------------------------------------------------------------------
module tb_top;
  import clp_pkg::*;

  localparam int RANDOM_ITEMS = 555;

  logic                  clk;
  logic                  rst_n           = 1'b0;
  logic                  in_valid        = 1'b0;
  logic                  in_stall;
  logic [CHAR_W-1:0]     in_char_code    = '0;
  logic                  in_line_end     = 1'b0;
  logic                  out_valid;
  logic                  out_stall       = 1'b0;
  logic                  out_kind;
  logic [CHAR_W-1:0]     out_name_byte;
  logic [STATUS_W-1:0]   out_status;
  logic [NAME_LEN_W-1:0] out_name_length;
  logic [OUT_POP_W-1:0]  out_population;
  int                    fail_count;
  int                    pending;

  logic [CHAR_W-1:0]     line_buf[$];
  int                    items_sent = 0;
  int                    burst_left = 0;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  country_line_parser i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_char_code    (in_char_code),
    .in_line_end     (in_line_end),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_kind        (out_kind),
    .out_name_byte   (out_name_byte),
    .out_status      (out_status),
    .out_name_length (out_name_length),
    .out_population  (out_population)
  );

  clp_checker i_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_char_code    (in_char_code),
    .in_line_end     (in_line_end),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_kind        (out_kind),
    .out_name_byte   (out_name_byte),
    .out_status      (out_status),
    .out_name_length (out_name_length),
    .out_population  (out_population),
    .fail_count      (fail_count),
    .pending         (pending)
  );

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // one input transaction; entered and left at a falling edge
  task automatic send_item(input logic [CHAR_W-1:0] c, input logic le);
    int gap;
    in_valid     <= 1'b1;
    in_char_code <= c;
    in_line_end  <= le;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
    @(negedge clk);
    if (burst_left > 0) begin
      burst_left--;
      gap = 0;
    end else begin
      gap = idle_len();
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic send_line();
    foreach (line_buf[i]) send_item(line_buf[i], 1'b0);
    send_item(CHAR_W'($urandom_range(0, 255)), 1'b1);
    line_buf.delete();
    if ($urandom_range(0, 19) == 0) burst_left = $urandom_range(30, 150);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  function automatic void push_str(input string s);
    for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
  endfunction

  function automatic void push_rep(input logic [CHAR_W-1:0] c, input int n);
    repeat (n) line_buf.push_back(c);
  endfunction

  function automatic logic [CHAR_W-1:0] rand_digit();
    return CHAR_W'(CH_ZERO + $urandom_range(0, 9));
  endfunction

  function automatic logic [CHAR_W-1:0] noise_byte();
    int r;
    r = $urandom_range(0, 9);
    if (r < 3) return CH_COMMA;
    if (r < 5) return rand_digit();
    if (r == 5) return CH_NEWLINE;
    return CHAR_W'($urandom_range(0, 255));
  endfunction

  function automatic void build_random_line();
    int n;
    logic [CHAR_W-1:0] c;
    if ($urandom_range(0, 99) < 75) begin
      n = ($urandom_range(0, 19) == 0) ? $urandom_range(55, 72) : $urandom_range(1, 12);
      repeat (n) begin
        do c = CHAR_W'($urandom_range(0, 255)); while (c == CH_COMMA);
        line_buf.push_back(c);
      end
      line_buf.push_back(CH_COMMA);
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 13) : $urandom_range(1, 9);
      repeat (n) line_buf.push_back(rand_digit());
      if ($urandom_range(0, 3) == 0) begin
        line_buf.push_back(CH_NEWLINE);
        repeat ($urandom_range(0, 4)) line_buf.push_back(CHAR_W'($urandom_range(0, 255)));
      end
      if ($urandom_range(0, 7) == 0)
        line_buf[$urandom_range(0, line_buf.size() - 1)] = noise_byte();
    end else begin
      repeat ($urandom_range(0, 20)) line_buf.push_back(noise_byte());
    end
  endfunction

  initial begin : recv_ctrl
    int hold;
    int quiet;
    hold  = 0;
    quiet = 0;
    forever begin
      @(negedge clk);
      if (quiet > 0) begin
        quiet--;
        out_stall <= 1'b0;
      end else if (hold > 0) begin
        hold--;
        out_stall <= 1'b1;
      end else if ($urandom_range(0, 199) == 0) begin
        quiet = $urandom_range(50, 300);
        out_stall <= 1'b0;
      end else begin
        hold = idle_len();
        out_stall <= (hold > 0);
        if (hold > 0) hold--;
      end
    end
  end

  initial begin : stimulus
    int random_start;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_line();
    push_str("Peru,0");
    send_line();
    push_str("Chad,4294967295");
    send_line();
    push_str("Oman,4294967296");
    send_line();
    push_str("Fiji,99999999999x");
    send_line();
    push_str(",123");
    send_line();
    push_str(",x");
    send_line();
    push_str(",,");
    send_line();
    push_str("Mali,1,2");
    send_line();
    push_str("Togo,,,,");
    send_line();
    push_str("Cuba,");
    send_line();
    push_str("Iran,\n");
    send_line();
    push_str("Laos,12a3");
    send_line();
    push_str("Iraq,");
    line_buf.push_back(8'h00);
    send_line();
    push_str("Chile,12\nzz9");
    send_line();
    push_str("Niger,4294967295\n7,");
    send_line();
    push_str("Peru");
    send_line();
    line_buf = '{8'h0A, 8'h00, 8'hFF, 8'h80, 8'h7F};
    push_str(",5");
    send_line();
    push_rep("A", NAME_LIMIT - 1);
    push_str(",42");
    send_line();
    push_rep("B", NAME_LIMIT);
    push_str(",42");
    send_line();
    push_rep("C", NAME_LIMIT + 6);
    push_str(",7");
    send_line();
    push_str("Nauru,00000000000000042");
    send_line();
    drain();

    random_start = items_sent;
    while (items_sent - random_start < RANDOM_ITEMS) begin
      build_random_line();
      send_line();
      if ($urandom_range(0, 39) == 0) drain();
    end

    drain();
    repeat (8) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("country_line_parser regression: pass");
    end else begin
      $display("country_line_parser regression: fail");
    end
    $finish;
  end

  initial begin : watchdog
    #(20_000_000);
    $display("country_line_parser regression: fail");
    $finish;
  end

endmodule
